>>> src/cfd_pkg.sv
package cfd_pkg;

	localparam int unsigned PhaseW = 5;
	localparam int unsigned WordW  = 32;
	localparam int unsigned ByteW  = 8;
	localparam int unsigned LimW   = 7;

	localparam logic [PhaseW-1:0] PH_IDLE      = 5'd0;
	localparam logic [PhaseW-1:0] PH_COORD_1ST = 5'd1;
	localparam logic [PhaseW-1:0] PH_X_END     = 5'd4;
	localparam logic [PhaseW-1:0] PH_Y_END     = 5'd8;
	localparam logic [PhaseW-1:0] PH_COORD_END = 5'd12;
	localparam logic [PhaseW-1:0] PH_THR_1ST   = 5'd13;
	localparam logic [PhaseW-1:0] PH_THR_END   = 5'd16;

	localparam logic [ByteW-1:0] START_COORD = 8'h63;
	localparam logic [ByteW-1:0] START_THR   = 8'h74;

	localparam logic [WordW-1:0] THR_LIMIT_W = 32'd100;
	localparam logic [LimW-1:0]  THR_LIMIT   = 7'd100;

	typedef struct packed {
		logic             accepted;
		logic [WordW-1:0] coord_x;
		logic [WordW-1:0] coord_y;
		logic [WordW-1:0] coord_z;
		logic             coord_update;
		logic [WordW-1:0] throttle_raw;
		logic [LimW-1:0]  throttle_limited;
		logic             throttle_update;
	} res_t;

	function automatic logic [WordW-1:0] put_byte(
		input logic [WordW-1:0] word,
		input logic [1:0]       lane,
		input logic [ByteW-1:0] b
	);
		logic [WordW-1:0] w;
		w = word;
		case (lane)
			2'd0: w[7:0]   = b;
			2'd1: w[15:8]  = b;
			2'd2: w[23:16] = b;
			default: w[31:24] = b;
		endcase
		return w;
	endfunction

endpackage

>>> src/cfd_parser.sv
module cfd_parser import cfd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [ByteW-1:0] byte_s1,
	output res_t             res
);

	logic [PhaseW-1:0] phase_q, phase_d, phase_m1;
	logic [WordW-1:0]  shadow_x_q, shadow_y_q, shadow_z_q, shadow_t_q;
	logic [WordW-1:0]  shadow_x_d, shadow_y_d, shadow_z_d, shadow_t_d;
	logic [WordW-1:0]  held_x_q, held_y_q, held_z_q, held_t_q;
	logic [WordW-1:0]  held_x_d, held_y_d, held_z_d, held_t_d;
	logic              is_idle, in_coord, in_thr, coord_done, thr_done;
	logic [1:0]        lane;

	assign phase_m1 = phase_q - 5'd1;
	// twelve is a multiple of four, so one lane select serves every word
	assign lane     = phase_m1[1:0];

	// unreachable phase codes behave as idle
	assign is_idle    = (phase_q == PH_IDLE) || (phase_q > PH_THR_END);
	assign in_coord   = !is_idle && (phase_q <= PH_COORD_END);
	assign in_thr     = !is_idle && !in_coord;
	assign coord_done = in_coord && (phase_q == PH_COORD_END);
	assign thr_done   = in_thr && (phase_q == PH_THR_END);

	always_comb begin
		shadow_x_d = shadow_x_q;
		shadow_y_d = shadow_y_q;
		shadow_z_d = shadow_z_q;
		shadow_t_d = shadow_t_q;
		if (in_coord && phase_q <= PH_X_END) begin
			shadow_x_d = put_byte(shadow_x_q, lane, byte_s1);
		end else if (in_coord && phase_q <= PH_Y_END) begin
			shadow_y_d = put_byte(shadow_y_q, lane, byte_s1);
		end else if (in_coord) begin
			shadow_z_d = put_byte(shadow_z_q, lane, byte_s1);
		end
		if (in_thr) begin
			shadow_t_d = put_byte(shadow_t_q, lane, byte_s1);
		end
	end

	always_comb begin
		held_x_d = coord_done ? shadow_x_d : held_x_q;
		held_y_d = coord_done ? shadow_y_d : held_y_q;
		held_z_d = coord_done ? shadow_z_d : held_z_q;
		held_t_d = thr_done   ? shadow_t_d : held_t_q;
	end

	always_comb begin
		if (is_idle) begin
			if (byte_s1 == START_COORD) begin
				phase_d = PH_COORD_1ST;
			end else if (byte_s1 == START_THR) begin
				phase_d = PH_THR_1ST;
			end else begin
				phase_d = PH_IDLE;
			end
		end else if (coord_done || thr_done) begin
			phase_d = PH_IDLE;
		end else begin
			phase_d = phase_q + 5'd1;
		end
	end

	always_comb begin
		res.accepted         = !is_idle || (byte_s1 == START_COORD) || (byte_s1 == START_THR);
		res.coord_x          = held_x_d;
		res.coord_y          = held_y_d;
		res.coord_z          = held_z_d;
		res.coord_update     = coord_done;
		res.throttle_raw     = held_t_d;
		res.throttle_limited = (held_t_d > THR_LIMIT_W) ? THR_LIMIT : held_t_d[LimW-1:0];
		res.throttle_update  = thr_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			held_x_q <= '0;
			held_y_q <= '0;
			held_z_q <= '0;
			held_t_q <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			held_x_q <= held_x_d;
			held_y_q <= held_y_d;
			held_z_q <= held_z_d;
			held_t_q <= held_t_d;
		end
	end

	// shadow words are always fully written before they are latched
	always_ff @(posedge clk) begin
		if (step) begin
			shadow_x_q <= shadow_x_d;
			shadow_y_q <= shadow_y_d;
			shadow_z_q <= shadow_z_d;
			shadow_t_q <= shadow_t_d;
		end
	end

endmodule

>>> src/command_frame_deframer.sv
// channel   signals                          width  transfer
// input     in_valid, in_ready, byte_in      8      in_valid & in_ready
// output    out_valid, out_ready, accepted,  1/32/7 out_valid & out_ready
//           coord_x/y/z, coord_update,
//           throttle_raw/limited, throttle_update
//
// one byte per cycle sustained while out_ready is high; a byte's result passes
// through the input register, the parse logic and then the result register
// before it is offered, and it transfers once out_ready is high.
// arst_n clears the parse phase and the latched words to idle and zero.
// a stalled result holds in the result register; the input register still
// takes a byte while it is empty or the result register is empty or being drained.
module command_frame_deframer import cfd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [ByteW-1:0] byte_in,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             accepted,
	output logic [WordW-1:0] coord_x,
	output logic [WordW-1:0] coord_y,
	output logic [WordW-1:0] coord_z,
	output logic             coord_update,
	output logic [WordW-1:0] throttle_raw,
	output logic [LimW-1:0]  throttle_limited,
	output logic             throttle_update
);

	logic             valid_s1, valid_s2, advance;
	logic [ByteW-1:0] byte_s1;
	res_t             res, res_s2;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= byte_in;
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	cfd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.byte_s1 (byte_s1),
		.res     (res)
	);

	assign out_valid        = valid_s2;
	assign accepted         = res_s2.accepted;
	assign coord_x          = res_s2.coord_x;
	assign coord_y          = res_s2.coord_y;
	assign coord_z          = res_s2.coord_z;
	assign coord_update     = res_s2.coord_update;
	assign throttle_raw     = res_s2.throttle_raw;
	assign throttle_limited = res_s2.throttle_limited;
	assign throttle_update  = res_s2.throttle_update;

	a_one_update: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(coord_update && throttle_update))
		else $error("coordinate and throttle update in one result");

	a_update_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (coord_update || throttle_update) |-> accepted)
		else $error("frame completed on a rejected byte");

	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (throttle_limited == ((throttle_raw > THR_LIMIT_W) ?
			THR_LIMIT : throttle_raw[LimW-1:0])))
		else $error("limited throttle does not match raw throttle");

	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_ready |-> in_ready)
		else $error("input stalled while the result side drains");

endmodule
